// ===== rtl/mft_pkg.sv =====
// Shared types and constants for the multi-turn feedback tracker.
// Used by every module under rtl; depends on nothing.
package mft_pkg;

  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned SLOT_W = 2;
  localparam int unsigned ID_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TURNS_W = 32;
  localparam int unsigned DIST_W = 51;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned COUNTS_PER_TURN_DEF = 8192;

  localparam logic [SLOT_W-1:0] YAW_SLOT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_YAW = 2'd3;

  localparam logic [ID_W-1:0] ID_SLOT0_RST = 11'd513;
  localparam logic [ID_W-1:0] ID_SLOT1_RST = 11'd514;
  localparam logic [ID_W-1:0] ID_SLOT2_RST = 11'd515;
  localparam logic [ID_W-1:0] ID_YAW_RST = 11'd517;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0] temp;
    logic [TURNS_W-1:0] turns;
    logic [15:0] zero;
  } slot_entry_t;

  typedef struct packed {
    logic hit;
    logic zero_req;
    logic [SLOT_W-1:0] slot;
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0] temp;
  } lookup_t;

  typedef struct packed {
    logic hit;
    logic [SLOT_W-1:0] slot;
    slot_entry_t entry;
  } upd_t;

endpackage

// ===== rtl/mft_match.sv =====
// Identifier registers and slot lookup for incoming beats.
// Depends on mft_pkg.
module mft_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mft_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mft_pkg::ID_W-1:0]     cfg_wdata_i,
  input  logic                         req_type_i,
  input  logic                         first_bus_i,
  input  logic [mft_pkg::ID_W-1:0]     frame_id_i,
  input  logic [mft_pkg::PAYLOAD_W-1:0] payload_i,
  input  logic [mft_pkg::SLOT_W-1:0]   zero_slot_i,
  output mft_pkg::lookup_t             lookup_o
);

  logic [mft_pkg::ID_W-1:0] id_q [mft_pkg::NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q[0] <= mft_pkg::ID_SLOT0_RST;
      id_q[1] <= mft_pkg::ID_SLOT1_RST;
      id_q[2] <= mft_pkg::ID_SLOT2_RST;
      id_q[3] <= mft_pkg::ID_YAW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mft_pkg::REG_ID_SLOT0: id_q[0] <= cfg_wdata_i;
        mft_pkg::REG_ID_SLOT1: id_q[1] <= cfg_wdata_i;
        mft_pkg::REG_ID_SLOT2: id_q[2] <= cfg_wdata_i;
        mft_pkg::REG_ID_YAW:   id_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                        frame_hit;
  logic [mft_pkg::SLOT_W-1:0]  frame_slot;

  // lowest slot wins on duplicate identifiers
  always_comb begin
    frame_hit  = 1'b0;
    frame_slot = '0;
    for (int i = mft_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (id_q[i] == frame_id_i) begin
        frame_hit  = 1'b1;
        frame_slot = mft_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    lookup_o.zero_req = req_type_i;
    lookup_o.hit      = req_type_i | (first_bus_i & frame_hit);
    lookup_o.slot     = req_type_i ? zero_slot_i : frame_slot;
    lookup_o.angle    = payload_i[63:48];
    lookup_o.speed    = payload_i[47:32];
    lookup_o.current  = payload_i[31:16];
    lookup_o.temp     = payload_i[15:8];
  end

endmodule

// ===== rtl/mft_slot_mem.sv =====
// Slot state memory with read-modify-write update, valid bits and forwarding.
// Depends on mft_pkg.
module mft_slot_mem #(
  parameter int unsigned COUNTS_PER_TURN = mft_pkg::COUNTS_PER_TURN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             in_fire_i,
  input  mft_pkg::lookup_t lookup_i,
  output logic             upd_valid_o,
  output mft_pkg::upd_t    upd_o
);

  localparam logic signed [16:0] HALF = 17'(COUNTS_PER_TURN / 2);

  mft_pkg::slot_entry_t mem_q [mft_pkg::NUM_SLOTS];
  logic [mft_pkg::NUM_SLOTS-1:0] valid_q;

  logic                 s1_valid_q;
  mft_pkg::lookup_t     s1_q;
  mft_pkg::slot_entry_t rdata_q;
  logic                 rvalid_q;

  logic                       fwd_valid_q;
  logic [mft_pkg::SLOT_W-1:0] fwd_slot_q;
  mft_pkg::slot_entry_t       fwd_data_q;

  mft_pkg::slot_entry_t cur;
  mft_pkg::slot_entry_t nxt;
  logic signed [16:0]   diff;
  logic                 wr_en;

  always_comb begin
    if (fwd_valid_q && fwd_slot_q == s1_q.slot) begin
      cur = fwd_data_q;
    end else if (rvalid_q) begin
      cur = rdata_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    nxt  = cur;
    diff = $signed({1'b0, s1_q.angle}) - $signed({1'b0, cur.angle});
    if (s1_q.zero_req) begin
      nxt.zero = cur.angle;
      if ($signed({1'b0, cur.angle}) > HALF) begin
        nxt.turns = cur.turns + mft_pkg::TURNS_W'(1);
      end
    end else begin
      nxt.angle   = s1_q.angle;
      nxt.speed   = s1_q.speed;
      nxt.current = s1_q.current;
      nxt.temp    = s1_q.temp;
      if (s1_q.slot != mft_pkg::YAW_SLOT) begin
        if (diff > HALF) begin
          nxt.turns = cur.turns - mft_pkg::TURNS_W'(1);
        end else if (diff < -HALF) begin
          nxt.turns = cur.turns + mft_pkg::TURNS_W'(1);
        end
      end
    end
  end

  assign wr_en = s1_valid_q & s1_q.hit;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (wr_en) begin
        mem_q[s1_q.slot] <= nxt;
      end
      rdata_q    <= mem_q[lookup_i.slot];
      s1_q       <= lookup_i;
      fwd_slot_q <= s1_q.slot;
      fwd_data_q <= nxt;
      upd_o.hit   <= s1_q.hit;
      upd_o.slot  <= s1_q.slot;
      upd_o.entry <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      upd_valid_o <= 1'b0;
    end else if (adv_i) begin
      if (wr_en) begin
        valid_q[s1_q.slot] <= 1'b1;
      end
      rvalid_q    <= valid_q[lookup_i.slot];
      s1_valid_q  <= in_fire_i;
      fwd_valid_q <= wr_en;
      upd_valid_o <= s1_valid_q;
    end
  end

endmodule

// ===== rtl/mft_dist.sv =====
// Distance pipeline (turns scale, offset, times ten) and the output register.
// Depends on mft_pkg.
module mft_dist #(
  parameter int unsigned COUNTS_PER_TURN = mft_pkg::COUNTS_PER_TURN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              upd_valid_i,
  input  mft_pkg::upd_t                     upd_i,
  output logic                              out_valid_o,
  output logic                              matched_o,
  output logic [mft_pkg::SLOT_W-1:0]        slot_o,
  output logic [15:0]                       angle_o,
  output logic signed [15:0]                speed_o,
  output logic signed [15:0]                current_o,
  output logic [7:0]                        temperature_o,
  output logic signed [mft_pkg::TURNS_W-1:0] turns_o,
  output logic signed [mft_pkg::DIST_W-1:0] distance_o
);

  localparam int unsigned PROD_W = mft_pkg::TURNS_W + $clog2(COUNTS_PER_TURN + 1) + 1;
  localparam int unsigned SUM_W = PROD_W + 1;
  localparam int unsigned CALC_W =
    (SUM_W + 4 > mft_pkg::DIST_W) ? SUM_W + 4 : mft_pkg::DIST_W;
  localparam logic signed [PROD_W-1:0] CPT_S = PROD_W'(COUNTS_PER_TURN);

  logic signed [PROD_W-1:0] prod;
  logic signed [16:0]       adiff;

  always_comb begin
    prod  = PROD_W'($signed(upd_i.entry.turns)) * CPT_S;
    adiff = $signed({1'b0, upd_i.entry.angle}) - $signed({1'b0, upd_i.entry.zero});
  end

  logic                     s3_valid_q;
  mft_pkg::upd_t            s3_q;
  logic signed [PROD_W-1:0] s3_prod_q;
  logic signed [16:0]       s3_adiff_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q       <= upd_i;
      s3_prod_q  <= prod;
      s3_adiff_q <= adiff;
    end
  end

  logic signed [SUM_W-1:0]  sum;
  logic signed [CALC_W-1:0] sum_ext;
  logic signed [CALC_W-1:0] dist_full;

  always_comb begin
    sum       = SUM_W'(s3_prod_q) + SUM_W'(s3_adiff_q);
    sum_ext   = CALC_W'(sum);
    dist_full = (sum_ext <<< 3) + (sum_ext <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (s3_q.hit) begin
        matched_o     <= 1'b1;
        slot_o        <= s3_q.slot;
        angle_o       <= s3_q.entry.angle;
        speed_o       <= $signed(s3_q.entry.speed);
        current_o     <= $signed(s3_q.entry.current);
        temperature_o <= s3_q.entry.temp;
        turns_o       <= $signed(s3_q.entry.turns);
        distance_o    <= (s3_q.slot == mft_pkg::YAW_SLOT) ? '0
                                                          : dist_full[mft_pkg::DIST_W-1:0];
      end else begin
        matched_o     <= 1'b0;
        slot_o        <= '0;
        angle_o       <= '0;
        speed_o       <= '0;
        current_o     <= '0;
        temperature_o <= '0;
        turns_o       <= '0;
        distance_o    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q  <= upd_valid_i;
      out_valid_o <= s3_valid_q;
    end
  end

endmodule

// ===== rtl/motor_feedback_multiturn_tracker_core.sv =====
// Top level of the multi-turn feedback tracker: lookup, slot memory, distance.
// Depends on mft_pkg, mft_match, mft_slot_mem and mft_dist.
//
//   channel | dir | handshake               | beat
//   --------+-----+-------------------------+---------------------------------------
//   cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//   in      | in  | in_valid_i / in_ready_o | req_type, first_bus, frame_id, payload,
//           |     |                         | zero_slot
//   out     | out | out_valid_o/out_ready_i | matched, slot, angle, speed, current,
//           |     |                         | temperature, turns, distance
//
// One beat per cycle in, one per cycle out, while the output is not stalled.
// Pipeline: memory read, read-modify-write with forwarding, turns scale, times ten.
// Reset clears identifiers to defaults and slot valid bits; no clearing pass.
// A stalled output holds the whole pipeline; in_ready_o follows the output register.
module motor_feedback_multiturn_tracker_core #(
  parameter int unsigned COUNTS_PER_TURN = mft_pkg::COUNTS_PER_TURN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mft_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mft_pkg::ID_W-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic                               first_bus_i,
  input  logic [mft_pkg::ID_W-1:0]           frame_id_i,
  input  logic [mft_pkg::PAYLOAD_W-1:0]      payload_i,
  input  logic [mft_pkg::SLOT_W-1:0]         zero_slot_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               matched_o,
  output logic [mft_pkg::SLOT_W-1:0]         slot_o,
  output logic [15:0]                        angle_o,
  output logic signed [15:0]                 speed_o,
  output logic signed [15:0]                 current_o,
  output logic [7:0]                         temperature_o,
  output logic signed [mft_pkg::TURNS_W-1:0] turns_o,
  output logic signed [mft_pkg::DIST_W-1:0]  distance_o
);

  logic             adv;
  logic             in_fire;
  mft_pkg::lookup_t lookup;
  logic             upd_valid;
  mft_pkg::upd_t    upd;

  assign adv        = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i & adv;

  mft_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .first_bus_i (first_bus_i),
    .frame_id_i  (frame_id_i),
    .payload_i   (payload_i),
    .zero_slot_i (zero_slot_i),
    .lookup_o    (lookup)
  );

  mft_slot_mem #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) u_slot_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_fire_i   (in_fire),
    .lookup_i    (lookup),
    .upd_valid_o (upd_valid),
    .upd_o       (upd)
  );

  mft_dist #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .upd_valid_i   (upd_valid),
    .upd_i         (upd),
    .out_valid_o   (out_valid_o),
    .matched_o     (matched_o),
    .slot_o        (slot_o),
    .angle_o       (angle_o),
    .speed_o       (speed_o),
    .current_o     (current_o),
    .temperature_o (temperature_o),
    .turns_o       (turns_o),
    .distance_o    (distance_o)
  );

endmodule

// ===== tb/tracker_tb_pkg.sv =====
// Request kinds and the expected result record for the tracker testbench.
// Depends on mft_pkg for the field widths.
package tracker_tb_pkg;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_ZERO  = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic                         matched;
    logic [mft_pkg::SLOT_W-1:0]   slot;
    logic [15:0]                  angle;
    logic [15:0]                  speed;
    logic [15:0]                  current;
    logic [7:0]                   temperature;
    logic [mft_pkg::TURNS_W-1:0]  turns;
    logic [mft_pkg::DIST_W-1:0]   distance;
  } feedback_t;

endpackage

// ===== tb/tracker_checker.sv =====
// Watches the config, input and output channels of the tracker, predicts each
// result beat from its own copy of the slot state, and counts mismatches.
// Depends on mft_pkg and tracker_tb_pkg.
module tracker_checker #(
  parameter int unsigned CPT = mft_pkg::COUNTS_PER_TURN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mft_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mft_pkg::ID_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                req_type_i,
  input  logic                                first_bus_i,
  input  logic [mft_pkg::ID_W-1:0]            frame_id_i,
  input  logic [mft_pkg::PAYLOAD_W-1:0]       payload_i,
  input  logic [mft_pkg::SLOT_W-1:0]          zero_slot_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                matched_i,
  input  logic [mft_pkg::SLOT_W-1:0]          slot_i,
  input  logic [15:0]                         angle_i,
  input  logic [15:0]                         speed_i,
  input  logic [15:0]                         current_i,
  input  logic [7:0]                          temperature_i,
  input  logic [mft_pkg::TURNS_W-1:0]         turns_i,
  input  logic [mft_pkg::DIST_W-1:0]          distance_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mft_pkg::*;
  import tracker_tb_pkg::*;

  localparam int HALF_TURN = int'(CPT / 2);

  logic [ID_W-1:0]    id_table   [NUM_SLOTS];
  logic [15:0]        pos_angle  [NUM_SLOTS];
  logic [15:0]        prev_angle [NUM_SLOTS];
  logic [15:0]        rpm        [NUM_SLOTS];
  logic [15:0]        amps       [NUM_SLOTS];
  logic [7:0]         temp_c     [NUM_SLOTS];
  logic [TURNS_W-1:0] rev_count  [NUM_SLOTS];
  logic [15:0]        zero_ref   [NUM_SLOTS];

  feedback_t expected_fb_q [$];
  int        fails;
  int        n_predicted;
  int        n_checked;

  function automatic feedback_t slot_report(input logic [SLOT_W-1:0] s);
    feedback_t r;
    longint    d;
    r.matched = 1'b1;
    r.slot = s;
    r.angle = pos_angle[s];
    r.speed = rpm[s];
    r.current = amps[s];
    r.temperature = temp_c[s];
    r.turns = rev_count[s];
    d = longint'($signed(rev_count[s])) * longint'(CPT)
        + longint'(pos_angle[s]) - longint'(zero_ref[s]);
    d = d * 10;
    r.distance = (s == YAW_SLOT) ? '0 : d[DIST_W-1:0];
    return r;
  endfunction

  function automatic feedback_t predict_feedback(input req_kind_e rt, input logic bus,
                                                 input logic [ID_W-1:0] fid,
                                                 input logic [PAYLOAD_W-1:0] pl,
                                                 input logic [SLOT_W-1:0] zs);
    feedback_t         r;
    logic [SLOT_W-1:0] s;
    logic              hit;
    int                jump;
    r = '0;
    if (rt == REQ_ZERO) begin
      zero_ref[zs] = pos_angle[zs];
      if (int'(zero_ref[zs]) > HALF_TURN) rev_count[zs] = rev_count[zs] + TURNS_W'(1);
      return slot_report(zs);
    end
    hit = 1'b0;
    s = '0;
    if (bus) begin
      for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
        if (id_table[j] == fid) begin
          hit = 1'b1;
          s = SLOT_W'(j);
        end
      end
    end
    if (!hit) return r;
    prev_angle[s] = pos_angle[s];
    pos_angle[s] = pl[63:48];
    rpm[s] = pl[47:32];
    amps[s] = pl[31:16];
    temp_c[s] = pl[15:8];
    if (s != YAW_SLOT) begin
      jump = int'(pos_angle[s]) - int'(prev_angle[s]);
      if (jump > HALF_TURN) rev_count[s] = rev_count[s] - TURNS_W'(1);
      else if (jump < -HALF_TURN) rev_count[s] = rev_count[s] + TURNS_W'(1);
    end
    return slot_report(s);
  endfunction

  function automatic bit field_ok(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
    if (want !== got) begin
      $display("%0t tracker_checker: %s mismatch, expected %0h, actual %0h",
               $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    feedback_t want;
    bit        ok;
    if (!rst_ni) begin
      id_table[REG_ID_SLOT0] = ID_SLOT0_RST;
      id_table[REG_ID_SLOT1] = ID_SLOT1_RST;
      id_table[REG_ID_SLOT2] = ID_SLOT2_RST;
      id_table[REG_ID_YAW] = ID_YAW_RST;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        pos_angle[j] = '0;
        prev_angle[j] = '0;
        rpm[j] = '0;
        amps[j] = '0;
        temp_c[j] = '0;
        rev_count[j] = '0;
        zero_ref[j] = '0;
      end
      expected_fb_q.delete();
      fails = 0;
      n_predicted = 0;
      n_checked = 0;
    end else begin
      if (cfg_we_i) id_table[cfg_idx_i] = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        expected_fb_q.push_back(predict_feedback(req_kind_e'(req_type_i), first_bus_i,
                                                 frame_id_i, payload_i, zero_slot_i));
        n_predicted++;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_fb_q.size() == 0) begin
          $display("%0t tracker_checker: result beat with nothing expected, actual slot %0d",
                   $time, slot_i);
          fails++;
        end else begin
          want = expected_fb_q.pop_front();
          n_checked++;
          ok = field_ok("matched", 64'(want.matched), 64'(matched_i));
          ok &= field_ok("slot", 64'(want.slot), 64'(slot_i));
          ok &= field_ok("angle", 64'(want.angle), 64'(angle_i));
          ok &= field_ok("speed", 64'(want.speed), 64'(speed_i));
          ok &= field_ok("current", 64'(want.current), 64'(current_i));
          ok &= field_ok("temperature", 64'(want.temperature), 64'(temperature_i));
          ok &= field_ok("turns", 64'(want.turns), 64'(turns_i));
          ok &= field_ok("distance", 64'(want.distance), 64'(distance_i));
          if (!ok) fails++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= n_predicted - n_checked;
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the multi-turn feedback tracker core.
// Depends on mft_pkg, tracker_tb_pkg, tracker_checker and the core itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mft_pkg::*;
  import tracker_tb_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [ID_W-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   req_type_i = 1'b0;
  logic                   first_bus_i = 1'b0;
  logic [ID_W-1:0]        frame_id_i = '0;
  logic [PAYLOAD_W-1:0]   payload_i = '0;
  logic [SLOT_W-1:0]      zero_slot_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   matched_o;
  logic [SLOT_W-1:0]      slot_o;
  logic [15:0]            angle_o;
  logic signed [15:0]     speed_o;
  logic signed [15:0]     current_o;
  logic [7:0]             temperature_o;
  logic signed [TURNS_W-1:0] turns_o;
  logic signed [DIST_W-1:0]  distance_o;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  logic [ID_W-1:0]      cur_ids [4] = '{ID_SLOT0_RST, ID_SLOT1_RST, ID_SLOT2_RST, ID_YAW_RST};
  logic [15:0]          tracked_angle [4] = '{16'd0, 16'd0, 16'd0, 16'd0};
  logic [CFG_IDX_W-1:0] reg_order [4] = '{REG_ID_SLOT0, REG_ID_SLOT1, REG_ID_SLOT2, REG_ID_YAW};
  logic [ID_W-1:0]      id_plans [4][4] = '{
    '{11'd0,   11'd2047, 11'd1,    11'd1024},
    '{11'd100, 11'd100,  11'd7,    11'd100},
    '{11'd2047, 11'd0,   11'd2046, 11'd2047},
    '{11'd513, 11'd514,  11'd515,  11'd517}
  };
  int sender_idle_plan [4] = '{0, 77, 0, 21};
  int receiver_stall_plan [4] = '{0, 0, 77, 21};

  always #5 clk_i = ~clk_i;

  motor_feedback_multiturn_tracker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .first_bus_i   (first_bus_i),
    .frame_id_i    (frame_id_i),
    .payload_i     (payload_i),
    .zero_slot_i   (zero_slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .matched_o     (matched_o),
    .slot_o        (slot_o),
    .angle_o       (angle_o),
    .speed_o       (speed_o),
    .current_o     (current_o),
    .temperature_o (temperature_o),
    .turns_o       (turns_o),
    .distance_o    (distance_o)
  );

  tracker_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .req_type_i    (req_type_i),
    .first_bus_i   (first_bus_i),
    .frame_id_i    (frame_id_i),
    .payload_i     (payload_i),
    .zero_slot_i   (zero_slot_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .matched_i     (matched_o),
    .slot_i        (slot_o),
    .angle_i       (angle_o),
    .speed_i       (speed_o),
    .current_i     (current_o),
    .temperature_i (temperature_o),
    .turns_i       (turns_o),
    .distance_i    (distance_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // hold off for a long stretch when asked, else stall at random
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [63:0] frame_payload(input logic [15:0] a, sp, cu,
                                                input logic [7:0] t, b7);
    return {a, sp, cu, t, b7};
  endfunction

  task automatic send_beat(input req_kind_e rt, input logic bus, input logic [ID_W-1:0] id,
                           input logic [PAYLOAD_W-1:0] pl, input logic [SLOT_W-1:0] zs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    first_bus_i <= bus;
    frame_id_i <= id;
    payload_i <= pl;
    zero_slot_i <= zs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_ids(input int p);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_order[i];
      cfg_wdata_i <= id_plans[p][i];
      cur_ids[i] = id_plans[p][i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_beat();
    int              k;
    logic [1:0]      hit;
    logic [15:0]     a0;
    logic [15:0]     a;
    logic            bus;
    logic [ID_W-1:0] id;
    logic [63:0]     pl;
    k = $urandom_range(99);
    pl = {$urandom, $urandom};
    if (k < 12) begin
      send_beat(REQ_ZERO, 1'($urandom_range(1)), ID_W'($urandom_range(2047)), pl,
                SLOT_W'($urandom_range(3)));
    end else if (k < 22) begin
      send_beat(REQ_FRAME, 1'($urandom_range(1)), ID_W'($urandom_range(2047)), pl,
                SLOT_W'($urandom_range(3)));
    end else begin
      id = cur_ids[2'($urandom_range(3))];
      hit = 2'd3;
      for (int j = 3; j >= 0; j--) if (cur_ids[j] == id) hit = 2'(j);
      a0 = tracked_angle[hit];
      case ($urandom_range(9))
        0, 1, 2, 3: a = a0 + 16'($urandom_range(400)) - 16'd200;
        4: a = a0 + 16'd4096;
        5: a = a0 + 16'd4097;
        6: a = a0 - 16'd4096;
        7: a = a0 - 16'd4097;
        8: a = 16'($urandom_range(8191));
        default: a = 16'($urandom);
      endcase
      pl[63:48] = a;
      bus = ($urandom_range(19) != 0);
      if (bus) tracked_angle[hit] = a;
      send_beat(REQ_FRAME, bus, id, pl, SLOT_W'($urandom_range(3)));
    end
  endtask

  initial begin
    #(5_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST, frame_payload(16'd0, 16'd0, 16'd0, 8'd0, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST,
              frame_payload(16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF), 2'd3);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST,
              frame_payload(16'd0, 16'h7FFF, 16'h8000, 8'd0, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST, frame_payload(16'd4096, 16'd5, 16'd6, 8'd7, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST, frame_payload(16'd8193, 16'd1, 16'd2, 8'd3, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST, frame_payload(16'd4096, 16'd1, 16'd2, 8'd3, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST, frame_payload(16'd0, 16'd1, 16'd2, 8'd3, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b0, ID_SLOT0_RST, frame_payload(16'd1234, 16'd1, 16'd2, 8'd3, 8'd0), 2'd0);
    send_beat(REQ_FRAME, 1'b1, 11'd0, {64{1'b1}}, 2'd1);
    send_beat(REQ_FRAME, 1'b1, 11'd2047, {64{1'b1}}, 2'd2);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT1_RST, frame_payload(16'd5000, 16'd9, 16'd9, 8'd9, 8'd0), 2'd0);
    send_beat(REQ_ZERO, 1'b1, ID_SLOT0_RST, '0, 2'd1);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT2_RST, frame_payload(16'd4096, 16'd0, 16'd0, 8'd0, 8'd0), 2'd0);
    send_beat(REQ_ZERO, 1'b0, 11'd0, '0, 2'd2);
    send_beat(REQ_FRAME, 1'b1, ID_YAW_RST,
              frame_payload(16'hFFFF, 16'h1234, 16'hFEDC, 8'h80, 8'h01), 2'd0);
    send_beat(REQ_ZERO, 1'b1, 11'd2047, {64{1'b1}}, YAW_SLOT);
    send_beat(REQ_FRAME, 1'b1, ID_YAW_RST, frame_payload(16'd0, 16'd0, 16'd0, 8'd0, 8'd0), 2'd0);
    send_beat(REQ_ZERO, 1'b1, ID_SLOT0_RST, '0, 2'd0);
    send_beat(REQ_FRAME, 1'b1, 11'd516, frame_payload(16'd77, 16'd1, 16'd1, 8'd1, 8'd1), 2'd0);
    send_beat(REQ_ZERO, 1'b0, 11'h5A5, 64'hA5A5_5A5A_A5A5_5A5A, 2'd0);
    send_beat(REQ_FRAME, 1'b1, ID_SLOT0_RST, {64{1'b1}}, 2'd0);
    send_beat(REQ_ZERO, 1'b1, ID_SLOT0_RST, '0, 2'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      load_ids(ph % 4);
      for (int i = 0; i < 4; i++) tracked_angle[i] = 16'd0;
      idle_pct = sender_idle_plan[ph % 4];
      stall_pct = receiver_stall_plan[ph % 4];
      if (ph == 4) hold_req = 1'b1;
      repeat (100) random_beat();
      drain();
    end

    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
